// ===== rtl/core/ethernet_ip_l4_header_parser_macros.svh =====
// ----------------------------------------------------------------------------
// ethernet_ip_l4_header_parser_macros
// assertion macros for the header parser checker (ethhp_checker)
// ----------------------------------------------------------------------------
`ifndef ETHERNET_IP_L4_HEADER_PARSER_MACROS_SVH
`define ETHERNET_IP_L4_HEADER_PARSER_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define EHP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication, clocked on clk, off during reset
`define EHP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// ===== rtl/core/ethhp_pkg.sv =====
// ----------------------------------------------------------------------------
// ethhp_pkg
// constants and codes for the ethernet / ip / l4 header parser
// ----------------------------------------------------------------------------
package ethhp_pkg;

	localparam int DEF_MAX_VLAN_TAGS = 2;

	localparam int POS_W        = 16;
	localparam int ETH_HDR_LEN  = 14;
	localparam int VLAN_TAG_LEN = 4;
	localparam int IPV4_MIN_HDR = 20;
	localparam int IPV6_HDR_LEN = 40;
	localparam int TCP_HDR_LEN  = 20;
	localparam int UDP_HDR_LEN  = 8;

	// byte offsets inside the frame and the l3 / l4 headers
	localparam logic [POS_W-1:0] POS_ETYPE_HI = 16'd12;
	localparam logic [POS_W-1:0] POS_ETYPE_LO = 16'd13;
	localparam logic [POS_W-1:0] REL_VER      = 16'd0;
	localparam logic [POS_W-1:0] REL_V4_PROTO = 16'd9;
	localparam logic [POS_W-1:0] REL_V4_SRC0  = 16'd12;
	localparam logic [POS_W-1:0] REL_V4_SRC3  = 16'd15;
	localparam logic [POS_W-1:0] REL_V6_NXT   = 16'd6;
	localparam logic [POS_W-1:0] REL_V6_SRC0  = 16'd8;
	localparam logic [POS_W-1:0] REL_V6_SRC7  = 16'd15;
	localparam logic [POS_W-1:0] REL_V6_SRC8  = 16'd16;
	localparam logic [POS_W-1:0] REL_V6_SRC15 = 16'd23;
	localparam logic [POS_W-1:0] L4_DPORT_HI  = 16'd2;
	localparam logic [POS_W-1:0] L4_DPORT_LO  = 16'd3;
	localparam logic [POS_W-1:0] L4_TCP_FLAGS = 16'd13;

	localparam logic [15:0] ETYPE_VLAN = 16'h8100;
	localparam logic [15:0] ETYPE_QINQ = 16'h88a8;
	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETYPE_IPV6 = 16'h86dd;

	localparam logic [3:0] VER_IPV4 = 4'd4;
	localparam logic [3:0] VER_IPV6 = 4'd6;

	localparam logic [7:0] PROTO_ICMP   = 8'd1;
	localparam logic [7:0] PROTO_TCP    = 8'd6;
	localparam logic [7:0] PROTO_UDP    = 8'd17;
	localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

	localparam int TCP_FIN_SYN = 1;
	localparam int TCP_FIN_RST = 2;
	localparam int TCP_FIN_ACK = 4;

	localparam logic [1:0] L3_NONE = 2'd0;
	localparam logic [1:0] L3_IPV4 = 2'd1;
	localparam logic [1:0] L3_IPV6 = 2'd2;

	localparam logic [1:0] L4_OTHER = 2'd0;
	localparam logic [1:0] L4_TCP   = 2'd1;
	localparam logic [1:0] L4_UDP   = 2'd2;
	localparam logic [1:0] L4_ICMP  = 2'd3;

	// output word layout
	localparam int OUT_DATA_W = 168;
	localparam int OUT_USER_W = 4;

	typedef struct packed {
		logic [4:0]  pad;
		logic [15:0] frame_length;
		logic        rst_seen;
		logic        synack_seen;
		logic        syn_seen;
		logic [15:0] dest_port;
		logic [63:0] source_low;
		logic [63:0] source_high;
	} out_data_t;

	typedef struct packed {
		logic [1:0] l4_class;
		logic [1:0] l3_class;
	} out_user_t;

	function automatic logic is_tag_type(input logic [15:0] kind);
		return (kind == ETYPE_VLAN) || (kind == ETYPE_QINQ);
	endfunction

endpackage

// ===== rtl/core/ethernet_ip_l4_header_parser.sv =====
// ----------------------------------------------------------------------------
// ethernet_ip_l4_header_parser
// byte-wide ethernet / vlan / ipv4 / ipv6 header parser with an l4 summary
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle on the slave side (tlast on the final byte)
// and emits one summary word per frame on the master side, in the cycle after
// the last byte is taken. Every byte goes through a single registered pass:
// the parse state updates in the cycle the byte is accepted, and the summary
// lands in an output register, so a new byte can be taken every cycle.
// s_axis_tready drops only while a finished summary sits in the output
// register and the master side does not take it.
// Up to MAX_VLAN_TAGS 802.1Q / 802.1ad tags are stripped; frames that are
// short, carry too many tags, or fail the ip version or length checks report
// l3 class 0 with all fields but the frame length cleared.

module ethernet_ip_l4_header_parser #(
	parameter int MAX_VLAN_TAGS = ethhp_pkg::DEF_MAX_VLAN_TAGS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [7:0]                       s_axis_tdata,  // frame_byte[7:0]
	input  logic                             s_axis_tlast,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// source_high[63:0], source_low[127:64], dest_port[143:128], syn_seen[144],
	// synack_seen[145], rst_seen[146], frame_length[162:147], zero pad[167:163]
	output logic [ethhp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// l3_class[1:0], l4_class[3:2]
	output logic [ethhp_pkg::OUT_USER_W-1:0] m_axis_tuser
);

	localparam int L3_LAST_INT = ethhp_pkg::ETH_HDR_LEN
		+ ethhp_pkg::VLAN_TAG_LEN * MAX_VLAN_TAGS;
	localparam int L3_W = $clog2(L3_LAST_INT + 1);
	localparam logic [L3_W-1:0] L3_FIRST = L3_W'(ethhp_pkg::ETH_HDR_LEN);
	localparam logic [L3_W-1:0] L3_LAST  = L3_W'(L3_LAST_INT);
	localparam logic [L3_W-1:0] TAG_STEP = L3_W'(ethhp_pkg::VLAN_TAG_LEN);
	localparam int PW = ethhp_pkg::POS_W;

	// per-frame parse state
	logic [PW-1:0]   pos_q;
	logic [15:0]     etype_q;
	logic [L3_W-1:0] l3_start_q;
	logic [3:0]      ihl_q;
	logic [3:0]      ver_q;
	logic [7:0]      proto_q;
	logic [63:0]     src_hi_q;
	logic [63:0]     src_lo_q;
	logic [15:0]     port_q;
	logic [7:0]      flags_q;
	logic            in_tag_q;

	logic [15:0]     etype_d;
	logic [L3_W-1:0] l3_start_d;
	logic [3:0]      ihl_d;
	logic [3:0]      ver_d;
	logic [7:0]      proto_d;
	logic [63:0]     src_hi_d;
	logic [63:0]     src_lo_d;
	logic [15:0]     port_d;
	logic [7:0]      flags_d;
	logic            in_tag_d;

	logic [PW-1:0]   len;
	logic            accept;

	logic                 out_valid_q;
	ethhp_pkg::out_data_t out_data_q;
	ethhp_pkg::out_user_t out_user_q;
	ethhp_pkg::out_data_t sum_data;
	ethhp_pkg::out_user_t sum_user;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign len           = (pos_q == '1) ? pos_q : pos_q + PW'(1);

	// next parse state for the byte on the input
	always_comb begin
		logic [PW-1:0] l3s;
		logic [PW-1:0] rel;
		logic [PW-1:0] l4;
		logic [PW-1:0] lrel;
		logic          is_v4;
		logic          is_v6;

		etype_d    = etype_q;
		l3_start_d = l3_start_q;
		ihl_d      = ihl_q;
		ver_d      = ver_q;
		proto_d    = proto_q;
		src_hi_d   = src_hi_q;
		src_lo_d   = src_lo_q;
		port_d     = port_q;
		flags_d    = flags_q;
		in_tag_d   = in_tag_q;

		l3s   = PW'(l3_start_q);
		rel   = pos_q - l3s;
		is_v4 = (etype_q == ethhp_pkg::ETYPE_IPV4);
		is_v6 = (etype_q == ethhp_pkg::ETYPE_IPV6);
		l4    = '0;
		lrel  = '0;

		if (pos_q == ethhp_pkg::POS_ETYPE_HI) begin
			etype_d[15:8] = s_axis_tdata;
		end else if (pos_q == ethhp_pkg::POS_ETYPE_LO) begin
			etype_d[7:0] = s_axis_tdata;
			in_tag_d = ethhp_pkg::is_tag_type(etype_d) && (l3_start_q < L3_LAST);
		end else if (pos_q >= PW'(ethhp_pkg::ETH_HDR_LEN)) begin
			if (in_tag_q) begin
				// inner ethertype sits in the last two bytes of each tag
				if (pos_q == l3s + PW'(2)) begin
					etype_d[15:8] = s_axis_tdata;
				end else if (pos_q == l3s + PW'(3)) begin
					etype_d[7:0] = s_axis_tdata;
					l3_start_d = l3_start_q + TAG_STEP;
					in_tag_d = ethhp_pkg::is_tag_type(etype_d) && (l3_start_d < L3_LAST);
				end
			end else if (pos_q >= l3s) begin
				if (rel == ethhp_pkg::REL_VER) begin
					ver_d = s_axis_tdata[7:4];
					ihl_d = s_axis_tdata[3:0];
				end
				if (is_v4) begin
					if (rel == ethhp_pkg::REL_V4_PROTO) begin
						proto_d = s_axis_tdata;
					end
					if (rel >= ethhp_pkg::REL_V4_SRC0 && rel <= ethhp_pkg::REL_V4_SRC3) begin
						src_lo_d = {32'd0, src_lo_q[23:0], s_axis_tdata};
					end
					l4 = PW'({ihl_d, 2'b00});
				end else if (is_v6) begin
					if (rel == ethhp_pkg::REL_V6_NXT) begin
						proto_d = s_axis_tdata;
					end
					if (rel >= ethhp_pkg::REL_V6_SRC0 && rel <= ethhp_pkg::REL_V6_SRC7) begin
						src_hi_d = {src_hi_q[55:0], s_axis_tdata};
					end
					if (rel >= ethhp_pkg::REL_V6_SRC8 && rel <= ethhp_pkg::REL_V6_SRC15) begin
						src_lo_d = {src_lo_q[55:0], s_axis_tdata};
					end
					l4 = PW'(ethhp_pkg::IPV6_HDR_LEN);
				end
				lrel = rel - l4;
				if ((is_v4 || is_v6) && rel >= l4) begin
					if (lrel == ethhp_pkg::L4_DPORT_HI) begin
						port_d[15:8] = s_axis_tdata;
					end else if (lrel == ethhp_pkg::L4_DPORT_LO) begin
						port_d[7:0] = s_axis_tdata;
					end else if (lrel == ethhp_pkg::L4_TCP_FLAGS) begin
						flags_d = s_axis_tdata;
					end
				end
			end
		end
	end

	// frame summary from the state after the last byte
	always_comb begin
		logic [PW-1:0] l3s;
		logic [PW-1:0] l4off_v4;
		logic [PW-1:0] l4off;
		logic          base_ok;
		logic          ok_v4;
		logic          ok_v6;
		logic          tcp_fits;
		logic          udp_fits;

		l3s      = PW'(l3_start_d);
		l4off_v4 = l3s + PW'({ihl_d, 2'b00});
		base_ok  = (len >= PW'(ethhp_pkg::ETH_HDR_LEN)) && !in_tag_d;
		ok_v4    = base_ok && (etype_d == ethhp_pkg::ETYPE_IPV4)
			&& (len >= l3s + PW'(ethhp_pkg::IPV4_MIN_HDR))
			&& (ver_d == ethhp_pkg::VER_IPV4) && (len >= l4off_v4);
		ok_v6    = base_ok && (etype_d == ethhp_pkg::ETYPE_IPV6)
			&& (len >= l3s + PW'(ethhp_pkg::IPV6_HDR_LEN))
			&& (ver_d == ethhp_pkg::VER_IPV6);
		l4off    = ok_v4 ? l4off_v4 : l3s + PW'(ethhp_pkg::IPV6_HDR_LEN);
		tcp_fits = (len >= l4off + PW'(ethhp_pkg::TCP_HDR_LEN));
		udp_fits = (len >= l4off + PW'(ethhp_pkg::UDP_HDR_LEN));

		sum_data = '0;
		sum_user = '0;
		sum_data.frame_length = len;

		if (ok_v4) begin
			sum_user.l3_class = ethhp_pkg::L3_IPV4;
			sum_data.source_low = {32'd0, src_lo_d[31:0]};
		end else if (ok_v6) begin
			sum_user.l3_class = ethhp_pkg::L3_IPV6;
			sum_data.source_high = src_hi_d;
			sum_data.source_low = src_lo_d;
		end

		if (ok_v4 || ok_v6) begin
			if (proto_d == ethhp_pkg::PROTO_TCP) begin
				sum_user.l4_class = ethhp_pkg::L4_TCP;
				if (tcp_fits) begin
					sum_data.dest_port = port_d;
					sum_data.syn_seen = flags_d[ethhp_pkg::TCP_FIN_SYN];
					sum_data.rst_seen = flags_d[ethhp_pkg::TCP_FIN_RST];
					sum_data.synack_seen = flags_d[ethhp_pkg::TCP_FIN_SYN]
						&& flags_d[ethhp_pkg::TCP_FIN_ACK];
				end
			end else if (proto_d == ethhp_pkg::PROTO_UDP) begin
				sum_user.l4_class = ethhp_pkg::L4_UDP;
				if (udp_fits) begin
					sum_data.dest_port = port_d;
				end
			end else if ((ok_v4 && proto_d == ethhp_pkg::PROTO_ICMP)
				|| (ok_v6 && proto_d == ethhp_pkg::PROTO_ICMPV6)) begin
				sum_user.l4_class = ethhp_pkg::L4_ICMP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			etype_q    <= '0;
			l3_start_q <= L3_FIRST;
			ihl_q      <= '0;
			ver_q      <= '0;
			proto_q    <= '0;
			src_hi_q   <= '0;
			src_lo_q   <= '0;
			port_q     <= '0;
			flags_q    <= '0;
			in_tag_q   <= 1'b0;
		end else if (accept) begin
			if (s_axis_tlast) begin
				pos_q      <= '0;
				etype_q    <= '0;
				l3_start_q <= L3_FIRST;
				ihl_q      <= '0;
				ver_q      <= '0;
				proto_q    <= '0;
				src_hi_q   <= '0;
				src_lo_q   <= '0;
				port_q     <= '0;
				flags_q    <= '0;
				in_tag_q   <= 1'b0;
			end else begin
				pos_q      <= len;
				etype_q    <= etype_d;
				l3_start_q <= l3_start_d;
				ihl_q      <= ihl_d;
				ver_q      <= ver_d;
				proto_q    <= proto_d;
				src_hi_q   <= src_hi_d;
				src_lo_q   <= src_lo_d;
				port_q     <= port_d;
				flags_q    <= flags_d;
				in_tag_q   <= in_tag_d;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && s_axis_tlast) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && s_axis_tlast) begin
			out_data_q <= sum_data;
			out_user_q <= sum_user;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule

// ===== rtl/core/ethhp_checker.sv =====
// ----------------------------------------------------------------------------
// ethhp_checker
// port-level checks on the header parser summary stream
// ----------------------------------------------------------------------------
`include "ethernet_ip_l4_header_parser_macros.svh"

module ethhp_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [ethhp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [ethhp_pkg::OUT_USER_W-1:0] m_axis_tuser
);

	ethhp_pkg::out_data_t od;
	ethhp_pkg::out_user_t ou;

	assign od = m_axis_tdata;
	assign ou = m_axis_tuser;

	// no l3 class code beyond ipv6
	`EHP_ASSERT_IMP(a_l3_code, m_axis_tvalid, ou.l3_class <= ethhp_pkg::L3_IPV6)

	// a frame that is not ip reports nothing but its length
	`EHP_ASSERT_IMP(a_non_ip_clear, m_axis_tvalid && ou.l3_class == ethhp_pkg::L3_NONE,
		ou.l4_class == ethhp_pkg::L4_OTHER && od.source_high == '0 && od.source_low == '0
		&& od.dest_port == '0 && !od.syn_seen && !od.synack_seen && !od.rst_seen)

	// tcp flags only on tcp, and syn+ack always carries syn
	`EHP_ASSERT_IMP(a_flags_tcp, m_axis_tvalid && ou.l4_class != ethhp_pkg::L4_TCP,
		!od.syn_seen && !od.synack_seen && !od.rst_seen)
	`EHP_ASSERT_IMP(a_synack_syn, m_axis_tvalid && od.synack_seen, od.syn_seen)

	// held summary stays put while stalled
	`EHP_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind ethernet_ip_l4_header_parser ethhp_checker u_ethhp_checker (.*);

// ===== verif/ethernet_ip_l4_header_parser_checker.sv =====
// ----------------------------------------------------------------------------
// ethernet_ip_l4_header_parser_checker
// watches both stream sides of the header parser and checks every summary
// ----------------------------------------------------------------------------
// Replays each accepted frame byte through its own copy of the parse state.
// On the byte with tlast it queues the summary that the parser must send.
// Each summary word taken on the master side is compared, field by field,
// with the oldest queued summary. Both sides are sampled on the falling edge,
// where the values that the next rising edge will see are already stable.

module ethernet_ip_l4_header_parser_checker #(
	parameter int MAX_VLAN_TAGS = ethhp_pkg::DEF_MAX_VLAN_TAGS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	input  logic                             s_axis_tready,
	input  logic [7:0]                       s_axis_tdata,  // frame_byte[7:0]
	input  logic                             s_axis_tlast,
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// source_high[63:0], source_low[127:64], dest_port[143:128], syn_seen[144],
	// synack_seen[145], rst_seen[146], frame_length[162:147], zero pad[167:163]
	input  logic [ethhp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// l3_class[1:0], l4_class[3:2]
	input  logic [ethhp_pkg::OUT_USER_W-1:0] m_axis_tuser,
	output int                               mismatches,
	output int                               pending
);

	// parse state of the frame in flight
	int          byte_count;
	logic [15:0] etype;
	int          l3_off;
	logic [3:0]  ihl_words;
	logic [3:0]  ver;
	logic [7:0]  proto;
	logic [63:0] src_hi;
	logic [63:0] src_lo;
	logic [15:0] dport;
	logic [7:0]  tcp_flags;
	bit          tag_open;
	int          tags_done;

	ethhp_pkg::out_data_t frame_summary_q[$];
	ethhp_pkg::out_user_t frame_class_q[$];
	int                   words_seen;

	function automatic bit more_tags();
		return (etype == ethhp_pkg::ETYPE_VLAN || etype == ethhp_pkg::ETYPE_QINQ)
			&& tags_done < MAX_VLAN_TAGS;
	endfunction

	task automatic clear_frame_state();
		byte_count = 0;
		etype      = '0;
		l3_off     = ethhp_pkg::ETH_HDR_LEN;
		ihl_words  = '0;
		ver        = '0;
		proto      = '0;
		src_hi     = '0;
		src_lo     = '0;
		dport      = '0;
		tcp_flags  = '0;
		tag_open   = 1'b0;
		tags_done  = 0;
	endtask

	task automatic capture_l3(input int rel, input logic [7:0] b);
		int l4_at;
		int lrel;
		if (rel == ethhp_pkg::REL_VER) begin
			ver       = b[7:4];
			ihl_words = b[3:0];
		end
		if (etype == ethhp_pkg::ETYPE_IPV4) begin
			if (rel == ethhp_pkg::REL_V4_PROTO)
				proto = b;
			if (rel >= ethhp_pkg::REL_V4_SRC0 && rel <= ethhp_pkg::REL_V4_SRC3)
				src_lo = {32'h0, src_lo[23:0], b};
			l4_at = int'(ihl_words) * 4;
		end else if (etype == ethhp_pkg::ETYPE_IPV6) begin
			if (rel == ethhp_pkg::REL_V6_NXT)
				proto = b;
			if (rel >= ethhp_pkg::REL_V6_SRC0 && rel <= ethhp_pkg::REL_V6_SRC7)
				src_hi = {src_hi[55:0], b};
			if (rel >= ethhp_pkg::REL_V6_SRC8 && rel <= ethhp_pkg::REL_V6_SRC15)
				src_lo = {src_lo[55:0], b};
			l4_at = ethhp_pkg::IPV6_HDR_LEN;
		end else begin
			return;
		end
		// small ihl puts the l4 window inside the ip header on purpose
		if (rel >= l4_at) begin
			lrel = rel - l4_at;
			if (lrel == ethhp_pkg::L4_DPORT_HI)
				dport[15:8] = b;
			else if (lrel == ethhp_pkg::L4_DPORT_LO)
				dport[7:0] = b;
			else if (lrel == ethhp_pkg::L4_TCP_FLAGS)
				tcp_flags = b;
		end
	endtask

	task automatic parse_frame_byte(input logic [7:0] b, input logic last);
		int                   p;
		int                   len;
		int                   l4_at;
		bit                   ok;
		logic [7:0]           icmp_code;
		ethhp_pkg::out_data_t d;
		ethhp_pkg::out_user_t u;
		p   = byte_count;
		len = (p < 65535) ? p + 1 : 65535;
		if (p == ethhp_pkg::POS_ETYPE_HI) begin
			etype[15:8] = b;
		end else if (p == ethhp_pkg::POS_ETYPE_LO) begin
			etype[7:0] = b;
			tag_open   = more_tags();
		end else if (p >= ethhp_pkg::ETH_HDR_LEN) begin
			if (tag_open) begin
				if (p == l3_off + 2) begin
					etype[15:8] = b;
				end else if (p == l3_off + 3) begin
					etype[7:0] = b;
					l3_off    += ethhp_pkg::VLAN_TAG_LEN;
					tags_done++;
					tag_open   = more_tags();
				end
			end else if (p >= l3_off) begin
				capture_l3(p - l3_off, b);
			end
		end
		byte_count = len;
		if (!last)
			return;

		d              = '0;
		u              = '0;
		d.frame_length = len[15:0];
		ok             = 1'b0;
		l4_at          = 0;
		icmp_code      = ethhp_pkg::PROTO_ICMP;
		if (len >= ethhp_pkg::ETH_HDR_LEN && !tag_open) begin
			if (etype == ethhp_pkg::ETYPE_IPV4) begin
				if (len >= l3_off + ethhp_pkg::IPV4_MIN_HDR && ver == ethhp_pkg::VER_IPV4 &&
				    len >= l3_off + int'(ihl_words) * 4) begin
					ok           = 1'b1;
					u.l3_class   = ethhp_pkg::L3_IPV4;
					l4_at        = l3_off + int'(ihl_words) * 4;
					d.source_low = {32'h0, src_lo[31:0]};
				end
			end else if (etype == ethhp_pkg::ETYPE_IPV6) begin
				if (len >= l3_off + ethhp_pkg::IPV6_HDR_LEN && ver == ethhp_pkg::VER_IPV6) begin
					ok            = 1'b1;
					u.l3_class    = ethhp_pkg::L3_IPV6;
					l4_at         = l3_off + ethhp_pkg::IPV6_HDR_LEN;
					icmp_code     = ethhp_pkg::PROTO_ICMPV6;
					d.source_high = src_hi;
					d.source_low  = src_lo;
				end
			end
		end
		if (ok) begin
			if (proto == ethhp_pkg::PROTO_TCP) begin
				u.l4_class = ethhp_pkg::L4_TCP;
				if (len >= l4_at + ethhp_pkg::TCP_HDR_LEN) begin
					d.dest_port   = dport;
					d.syn_seen    = tcp_flags[ethhp_pkg::TCP_FIN_SYN];
					d.rst_seen    = tcp_flags[ethhp_pkg::TCP_FIN_RST];
					d.synack_seen = tcp_flags[ethhp_pkg::TCP_FIN_SYN]
						& tcp_flags[ethhp_pkg::TCP_FIN_ACK];
				end
			end else if (proto == ethhp_pkg::PROTO_UDP) begin
				u.l4_class = ethhp_pkg::L4_UDP;
				if (len >= l4_at + ethhp_pkg::UDP_HDR_LEN)
					d.dest_port = dport;
			end else if (proto == icmp_code) begin
				u.l4_class = ethhp_pkg::L4_ICMP;
			end
		end
		frame_summary_q.push_back(d);
		frame_class_q.push_back(u);
		clear_frame_state();
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
	                           input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("summary word %0d: %s expected 0x%0h, got 0x%0h",
				         words_seen, name, want, got);
		end
	endtask

	task automatic check_summary();
		ethhp_pkg::out_data_t want_d;
		ethhp_pkg::out_user_t want_u;
		ethhp_pkg::out_data_t got_d;
		ethhp_pkg::out_user_t got_u;
		got_d = ethhp_pkg::out_data_t'(m_axis_tdata);
		got_u = ethhp_pkg::out_user_t'(m_axis_tuser);
		if (frame_summary_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("summary word %0d arrived with no frame ended: data 0x%0h user 0x%0h",
				         words_seen, m_axis_tdata, m_axis_tuser);
			return;
		end
		want_d = frame_summary_q.pop_front();
		want_u = frame_class_q.pop_front();
		check_field("l3_class", 64'(want_u.l3_class), 64'(got_u.l3_class));
		check_field("l4_class", 64'(want_u.l4_class), 64'(got_u.l4_class));
		check_field("source_high", want_d.source_high, got_d.source_high);
		check_field("source_low", want_d.source_low, got_d.source_low);
		check_field("dest_port", 64'(want_d.dest_port), 64'(got_d.dest_port));
		check_field("syn_seen", 64'(want_d.syn_seen), 64'(got_d.syn_seen));
		check_field("synack_seen", 64'(want_d.synack_seen), 64'(got_d.synack_seen));
		check_field("rst_seen", 64'(want_d.rst_seen), 64'(got_d.rst_seen));
		check_field("frame_length", 64'(want_d.frame_length), 64'(got_d.frame_length));
		check_field("pad", 64'(want_d.pad), 64'(got_d.pad));
	endtask

	initial begin
		mismatches = 0;
		pending    = 0;
		words_seen = 0;
		clear_frame_state();
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			clear_frame_state();
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				parse_frame_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				check_summary();
				words_seen++;
			end
			pending = frame_summary_q.size();
		end
	end

endmodule

// ===== verif/ethernet_ip_l4_header_parser_tb.sv =====
// ----------------------------------------------------------------------------
// ethernet_ip_l4_header_parser_tb
// frame stimulus and verdict for the ethernet / ip / l4 header parser
// ----------------------------------------------------------------------------
// Sends a directed set of frames (short frames, vlan stacks, bad versions,
// truncated ip and l4 headers, small ihl and every l4 class), waits for all
// summaries, then random frames that are mostly well formed with random
// content. The sender works in bursts, the receiver stalls in phases that
// include long holds. The checker module predicts and compares every summary
// word.

module ethernet_ip_l4_header_parser_tb;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int MIN_BYTES   = 1300;

	logic                             clk;
	logic                             arst_n;
	logic                             s_axis_tvalid;
	logic                             s_axis_tready;
	logic [7:0]                       s_axis_tdata;   // frame_byte[7:0]
	logic                             s_axis_tlast;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready;
	// source_high[63:0], source_low[127:64], dest_port[143:128], syn_seen[144],
	// synack_seen[145], rst_seen[146], frame_length[162:147], zero pad[167:163]
	logic [ethhp_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	// l3_class[1:0], l4_class[3:2]
	logic [ethhp_pkg::OUT_USER_W-1:0] m_axis_tuser;

	int mismatches;
	int pending;
	int cycle_count;

	logic [7:0] frame_bytes[$];
	int         burst_left;
	bit         steady;
	int         bytes_sent;

	ethernet_ip_l4_header_parser DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	ethernet_ip_l4_header_parser_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial cycle_count = 0;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic [15:0] pick_tag();
		return $urandom_range(0, 1) ? ethhp_pkg::ETYPE_VLAN : ethhp_pkg::ETYPE_QINQ;
	endfunction

	// frame: macs, tag stack, l3 header, l4 bytes; cut > 0 truncates
	task automatic build_frame(input int n_tags, input logic [15:0] kind,
	                           input logic [3:0] ver, input logic [3:0] ihl,
	                           input logic [7:0] proto, input logic [7:0] flags,
	                           input int l4_len, input int cut);
		int          i;
		int          base;
		int          hdr_len;
		logic [15:0] ty;
		frame_bytes.delete();
		for (i = 0; i < 12; i++)
			frame_bytes.push_back(8'($urandom_range(0, 255)));
		ty = (n_tags > 0) ? pick_tag() : kind;
		frame_bytes.push_back(ty[15:8]);
		frame_bytes.push_back(ty[7:0]);
		for (i = 0; i < n_tags; i++) begin
			frame_bytes.push_back(8'($urandom_range(0, 255)));
			frame_bytes.push_back(8'($urandom_range(0, 255)));
			ty = (i + 1 < n_tags) ? pick_tag() : kind;
			frame_bytes.push_back(ty[15:8]);
			frame_bytes.push_back(ty[7:0]);
		end
		base = frame_bytes.size();
		if (kind == ethhp_pkg::ETYPE_IPV4) begin
			hdr_len = (ihl >= 5) ? int'(ihl) * 4 : ethhp_pkg::IPV4_MIN_HDR;
			for (i = 0; i < hdr_len; i++)
				frame_bytes.push_back(8'($urandom_range(0, 255)));
			frame_bytes[base]     = {ver, ihl};
			frame_bytes[base + 9] = proto;
		end else if (kind == ethhp_pkg::ETYPE_IPV6) begin
			for (i = 0; i < ethhp_pkg::IPV6_HDR_LEN; i++)
				frame_bytes.push_back(8'($urandom_range(0, 255)));
			frame_bytes[base]     = {ver, 4'($urandom_range(0, 15))};
			frame_bytes[base + 6] = proto;
		end
		base = frame_bytes.size();
		for (i = 0; i < l4_len; i++)
			frame_bytes.push_back(8'($urandom_range(0, 255)));
		if (l4_len > 13)
			frame_bytes[base + 13] = flags;
		if (cut > 0)
			while (frame_bytes.size() > cut)
				void'(frame_bytes.pop_back());
	endtask

	task automatic random_frame();
		int          r;
		int          n_tags;
		logic [15:0] kind;
		logic [3:0]  ver;
		logic [3:0]  ihl;
		logic [7:0]  proto;
		logic [7:0]  flags;
		int          l4_len;
		int          cut;
		r = $urandom_range(0, 19);
		n_tags = (r < 10) ? 0 : (r < 15) ? 1 : (r < 19) ? 2 : 3;
		r = $urandom_range(0, 19);
		if (r < 9)
			kind = ethhp_pkg::ETYPE_IPV4;
		else if (r < 16)
			kind = ethhp_pkg::ETYPE_IPV6;
		else if (r < 18)
			kind = 16'($urandom_range(0, 65535));
		else
			kind = pick_tag();
		if ($urandom_range(0, 9) != 0)
			ver = (kind == ethhp_pkg::ETYPE_IPV6) ? ethhp_pkg::VER_IPV6 : ethhp_pkg::VER_IPV4;
		else
			ver = 4'($urandom_range(0, 15));
		r = $urandom_range(0, 9);
		ihl = (r < 7) ? 4'd5 : (r < 9) ? 4'($urandom_range(6, 15)) : 4'($urandom_range(0, 4));
		case ($urandom_range(0, 9))
			0, 1, 2, 3: proto = ethhp_pkg::PROTO_TCP;
			4, 5, 6:    proto = ethhp_pkg::PROTO_UDP;
			7:          proto = (kind == ethhp_pkg::ETYPE_IPV6) ?
			                    ethhp_pkg::PROTO_ICMPV6 : ethhp_pkg::PROTO_ICMP;
			8:          proto = (kind == ethhp_pkg::ETYPE_IPV6) ?
			                    ethhp_pkg::PROTO_ICMP : ethhp_pkg::PROTO_ICMPV6;
			default:    proto = 8'($urandom_range(0, 255));
		endcase
		case ($urandom_range(0, 9))
			0:       flags = 8'h02;
			1:       flags = 8'h12;
			2:       flags = 8'h04;
			default: flags = 8'($urandom_range(0, 255));
		endcase
		if (proto == ethhp_pkg::PROTO_TCP)
			l4_len = ($urandom_range(0, 3) != 0) ? $urandom_range(20, 32) : $urandom_range(0, 19);
		else if (proto == ethhp_pkg::PROTO_UDP)
			l4_len = ($urandom_range(0, 4) != 0) ? $urandom_range(8, 20) : $urandom_range(0, 7);
		else
			l4_len = $urandom_range(0, 24);
		build_frame(n_tags, kind, ver, ihl, proto, flags, l4_len, 0);
		cut = 0;
		if ($urandom_range(0, 6) == 0)
			cut = $urandom_range(1, frame_bytes.size());
		if (cut > 0)
			while (frame_bytes.size() > cut)
				void'(frame_bytes.pop_back());
	endtask

	task automatic send_frame();
		int i;
		int gap;
		bit taken;
		steady = ($urandom_range(0, 3) == 0);
		for (i = 0; i < frame_bytes.size(); i++) begin
			if (burst_left == 0) begin
				gap = steady ? 0 : ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					s_axis_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 24);
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= frame_bytes[i];
			s_axis_tlast  <= (i == frame_bytes.size() - 1);
			do begin
				@(negedge clk);
				taken = s_axis_tready;
				@(posedge clk);
			end while (!taken);
			burst_left--;
			bytes_sent++;
		end
	endtask

	// receiver: stall phases of its own, every sixth one a long hold
	initial begin : receiver
		int phase_no;
		int span;
		int mode;
		int i;
		m_axis_tready = 1'b0;
		phase_no      = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (phase_no % 6 == 2) begin
				m_axis_tready <= 1'b0;
				repeat (250) @(posedge clk);
			end else begin
				span = $urandom_range(20, 100);
				mode = $urandom_range(0, 3);
				for (i = 0; i < span; i++) begin
					case (mode)
						0:       m_axis_tready <= 1'b1;
						1:       m_axis_tready <= 1'($urandom_range(0, 1));
						2:       m_axis_tready <= (i % 3 == 0);
						default: m_axis_tready <= ($urandom_range(0, 3) == 0);
					endcase
					@(posedge clk);
				end
			end
			phase_no++;
		end
	end

	initial begin : stimulus
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		burst_left    = 0;
		bytes_sent    = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short frames and frames that end inside a tag
		build_frame(0, ethhp_pkg::ETYPE_IPV4, ethhp_pkg::VER_IPV4, 4'd5,
		            ethhp_pkg::PROTO_TCP, 8'h02, 20, 1);
		send_frame();
		build_frame(0, ethhp_pkg::ETYPE_IPV4, ethhp_pkg::VER_IPV4, 4'd5,
		            ethhp_pkg::PROTO_TCP, 8'h02, 20, 13);
		send_frame();
		build_frame(0, ethhp_pkg::ETYPE_IPV4, ethhp_pkg::VER_IPV4, 4'd5,
		            ethhp_pkg::PROTO_UDP, 8'h00, 8, 14);
		send_frame();
		build_frame(1, ethhp_pkg::ETYPE_IPV4, ethhp_pkg::VER_IPV4, 4'd5,
		            ethhp_pkg::PROTO_UDP, 8'h00, 8, 16);
		send_frame();
		// tag stacks: two allowed, three too many
		build_frame(2, ethhp_pkg::ETYPE_IPV4, ethhp_pkg::VER_IPV4, 4'd5,
		            ethhp_pkg::PROTO_TCP, 8'h12, 20, 0);
		send_frame();
		build_frame(3, ethhp_pkg::ETYPE_IPV4, ethhp_pkg::VER_IPV4, 4'd5,
		            ethhp_pkg::PROTO_TCP, 8'h02, 20, 0);
		send_frame();
		build_frame(1, ethhp_pkg::ETYPE_IPV6, ethhp_pkg::VER_IPV6, 4'd0,
		            ethhp_pkg::PROTO_UDP, 8'h00, 8, 0);
		send_frame();
		// ipv4 options, small ihl, bad version, short headers
		build_frame(0, ethhp_pkg::ETYPE_IPV4, ethhp_pkg::VER_IPV4, 4'd7,
		            ethhp_pkg::PROTO_UDP, 8'h00, 8, 0);
		send_frame();
		build_frame(0, ethhp_pkg::ETYPE_IPV4, ethhp_pkg::VER_IPV4, 4'd2,
		            ethhp_pkg::PROTO_TCP, 8'h16, 30, 0);
		send_frame();
		build_frame(0, ethhp_pkg::ETYPE_IPV4, ethhp_pkg::VER_IPV4, 4'd0,
		            ethhp_pkg::PROTO_UDP, 8'h00, 10, 0);
		send_frame();
		build_frame(0, ethhp_pkg::ETYPE_IPV4, ethhp_pkg::VER_IPV6, 4'd5,
		            ethhp_pkg::PROTO_TCP, 8'h02, 20, 0);
		send_frame();
		build_frame(0, ethhp_pkg::ETYPE_IPV4, ethhp_pkg::VER_IPV4, 4'd5,
		            ethhp_pkg::PROTO_TCP, 8'h02, 20, 30);
		send_frame();
		build_frame(0, ethhp_pkg::ETYPE_IPV4, ethhp_pkg::VER_IPV4, 4'd15,
		            ethhp_pkg::PROTO_UDP, 8'h00, 8, 54);
		send_frame();
		// short l4 headers and every l4 class
		build_frame(0, ethhp_pkg::ETYPE_IPV4, ethhp_pkg::VER_IPV4, 4'd5,
		            ethhp_pkg::PROTO_TCP, 8'h17, 19, 0);
		send_frame();
		build_frame(0, ethhp_pkg::ETYPE_IPV4, ethhp_pkg::VER_IPV4, 4'd5,
		            ethhp_pkg::PROTO_UDP, 8'h00, 7, 0);
		send_frame();
		build_frame(0, ethhp_pkg::ETYPE_IPV4, ethhp_pkg::VER_IPV4, 4'd5,
		            ethhp_pkg::PROTO_ICMP, 8'h00, 8, 0);
		send_frame();
		build_frame(0, ethhp_pkg::ETYPE_IPV4, ethhp_pkg::VER_IPV4, 4'd5,
		            ethhp_pkg::PROTO_ICMPV6, 8'h00, 8, 0);
		send_frame();
		build_frame(0, ethhp_pkg::ETYPE_IPV6, ethhp_pkg::VER_IPV6, 4'd0,
		            ethhp_pkg::PROTO_TCP, 8'h04, 20, 0);
		send_frame();
		build_frame(0, ethhp_pkg::ETYPE_IPV6, ethhp_pkg::VER_IPV6, 4'd0,
		            ethhp_pkg::PROTO_TCP, 8'hff, 40, 0);
		send_frame();
		build_frame(0, ethhp_pkg::ETYPE_IPV6, ethhp_pkg::VER_IPV6, 4'd0,
		            ethhp_pkg::PROTO_ICMPV6, 8'h00, 8, 0);
		send_frame();
		build_frame(0, ethhp_pkg::ETYPE_IPV6, ethhp_pkg::VER_IPV6, 4'd0,
		            ethhp_pkg::PROTO_ICMP, 8'h00, 8, 0);
		send_frame();
		build_frame(0, ethhp_pkg::ETYPE_IPV6, ethhp_pkg::VER_IPV4, 4'd0,
		            ethhp_pkg::PROTO_UDP, 8'h00, 8, 0);
		send_frame();
		build_frame(0, ethhp_pkg::ETYPE_IPV6, ethhp_pkg::VER_IPV6, 4'd0,
		            ethhp_pkg::PROTO_UDP, 8'h00, 8, 50);
		send_frame();
		build_frame(0, 16'h0806, ethhp_pkg::VER_IPV4, 4'd5,
		            ethhp_pkg::PROTO_TCP, 8'h00, 46, 0);
		send_frame();

		// hold the input until every summary so far is out
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		while (bytes_sent < MIN_BYTES) begin
			random_frame();
			send_frame();
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatches == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
